// File: src/i2cbpg_pkg.sv
package i2cbpg_pkg;

  localparam int unsigned PhaseW = 5;

  localparam logic [1:0] FuncStart = 2'd0;
  localparam logic [1:0] FuncStop  = 2'd1;
  localparam logic [1:0] FuncWrite = 2'd2;
  localparam logic [1:0] FuncRead  = 2'd3;

  localparam logic [PhaseW-1:0] LastStart = PhaseW'(1);
  localparam logic [PhaseW-1:0] LastStop  = PhaseW'(2);
  localparam logic [PhaseW-1:0] LastByte  = PhaseW'(18);
  localparam logic [PhaseW-1:0] AckLow    = PhaseW'(16);
  localparam logic [PhaseW-1:0] AckHigh   = PhaseW'(17);

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] tx_byte;
    logic       master_ack;
    logic [7:0] read_bits;
    logic       slave_ack_sample;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_enable;
    logic       sda_level;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       last;
  } out_t;

  typedef struct packed {
    logic              load;
    logic              emit;
    logic [PhaseW-1:0] phase;
  } cmd_t;

  typedef struct packed {
    logic              out_free;
    logic [PhaseW-1:0] last_phase;
  } status_t;

endpackage

// File: src/i2cbpg_ctrl.sv
module i2cbpg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  i2cbpg_pkg::status_t status_i,
  output i2cbpg_pkg::cmd_t    cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic                            state_q, state_d;
  logic [i2cbpg_pkg::PhaseW-1:0]   phase_q, phase_d;
  logic                            emit;

  assign in_ready_o = (state_q == StIdle);
  assign emit       = (state_q == StRun) && status_i.out_free;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StRun;
          phase_d = '0;
        end
      end
      StRun: begin
        if (emit) begin
          phase_d = phase_q + 1'b1;
          if (phase_q == status_i.last_phase) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  assign cmd_o.load  = in_ready_o && in_valid_i;
  assign cmd_o.emit  = emit;
  assign cmd_o.phase = phase_q;

endmodule

// File: src/i2cbpg_dp.sv
module i2cbpg_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  i2cbpg_pkg::in_t     in_data_i,
  input  i2cbpg_pkg::cmd_t    cmd_i,
  output i2cbpg_pkg::status_t status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output i2cbpg_pkg::out_t    out_data_o
);

  i2cbpg_pkg::in_t  item_q;
  i2cbpg_pkg::out_t out_q, phase_out;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       tx_shift;
  logic [i2cbpg_pkg::PhaseW-1:0] p;

  assign p        = cmd_i.phase;
  assign tx_shift = item_q.tx_byte << p[3:1];

  always_comb begin
    status_o.out_free = !out_valid_q || out_ready_i;
    case (item_q.func)
      i2cbpg_pkg::FuncStart: status_o.last_phase = i2cbpg_pkg::LastStart;
      i2cbpg_pkg::FuncStop:  status_o.last_phase = i2cbpg_pkg::LastStop;
      default:               status_o.last_phase = i2cbpg_pkg::LastByte;
    endcase
  end

  always_comb begin
    phase_out = '0;
    phase_out.last = (p == status_o.last_phase);
    unique case (item_q.func)
      i2cbpg_pkg::FuncStart: begin
        phase_out.scl_level  = 1'b1;
        phase_out.sda_enable = p[0];
      end
      i2cbpg_pkg::FuncStop: begin
        phase_out.scl_level  = (p != '0);
        phase_out.sda_enable = (p != i2cbpg_pkg::LastStop);
      end
      i2cbpg_pkg::FuncWrite: begin
        if (p < i2cbpg_pkg::AckLow) begin
          phase_out.scl_level  = p[0];
          phase_out.sda_enable = 1'b1;
          phase_out.sda_level  = tx_shift[7];
        end else begin
          phase_out.scl_level = (p == i2cbpg_pkg::AckHigh);
          phase_out.ack_seen  = (p == i2cbpg_pkg::LastByte) && item_q.slave_ack_sample;
        end
      end
      i2cbpg_pkg::FuncRead: begin
        if (p < i2cbpg_pkg::AckLow) begin
          phase_out.scl_level = p[0];
        end else begin
          phase_out.scl_level  = (p == i2cbpg_pkg::AckHigh);
          phase_out.sda_enable = 1'b1;
          phase_out.sda_level  = item_q.master_ack;
          if (p == i2cbpg_pkg::LastByte) begin
            phase_out.rx_byte = item_q.read_bits;
          end
        end
      end
      default: phase_out = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.emit) begin
      out_q <= phase_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: src/i2c_master_byte_phase_generator.sv
// Each command is taken in the idle state, then gives one bus phase per cycle while
// the output is taken.
// A command's first phase is registered once the controller is in its run state.
// The phase counter in the controller steps once per output transfer, so output
// stalls stretch a command; the next command is taken once its last phase is loaded.
// Reset clears the controller state and the output valid flag; no stored data.
module i2c_master_byte_phase_generator (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  i2cbpg_pkg::in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output i2cbpg_pkg::out_t out_data_o
);

  i2cbpg_pkg::cmd_t    cmd;
  i2cbpg_pkg::status_t status;

  i2cbpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  i2cbpg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready_o;
  i2cbpg_pkg::in_t  in_data;
  logic             out_valid_o;
  logic             out_ready;
  i2cbpg_pkg::out_t out_data_o;

  bit idle_en = 1'b1;
  bit hold_req = 1'b0;
  int fail_count = 0;
  i2cbpg_pkg::out_t expected_phases[$];

  always #10 clk = ~clk;

  i2c_master_byte_phase_generator DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  function automatic void push_phase(input logic scl, input logic en, input logic lvl,
                                     input logic [7:0] rx, input logic ack,
                                     input logic fin);
    i2cbpg_pkg::out_t ph;
    ph.scl_level  = scl;
    ph.sda_enable = en;
    ph.sda_level  = en ? lvl : 1'b0;
    ph.rx_byte    = rx;
    ph.ack_seen   = ack;
    ph.last       = fin;
    expected_phases.push_back(ph);
  endfunction

  function automatic void predict_phases(input i2cbpg_pkg::in_t cmd);
    case (cmd.func)
      i2cbpg_pkg::FuncStart: begin
        push_phase(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        push_phase(1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1);
      end
      i2cbpg_pkg::FuncStop: begin
        push_phase(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        push_phase(1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        push_phase(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1);
      end
      i2cbpg_pkg::FuncWrite: begin
        for (int i = 7; i >= 0; i--) begin
          push_phase(1'b0, 1'b1, cmd.tx_byte[i], 8'h00, 1'b0, 1'b0);
          push_phase(1'b1, 1'b1, cmd.tx_byte[i], 8'h00, 1'b0, 1'b0);
        end
        push_phase(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        push_phase(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        push_phase(1'b0, 1'b0, 1'b0, 8'h00, cmd.slave_ack_sample, 1'b1);
      end
      default: begin
        for (int i = 0; i < 8; i++) begin
          push_phase(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
          push_phase(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        end
        push_phase(1'b0, 1'b1, cmd.master_ack, 8'h00, 1'b0, 1'b0);
        push_phase(1'b1, 1'b1, cmd.master_ack, 8'h00, 1'b0, 1'b0);
        push_phase(1'b0, 1'b1, cmd.master_ack, cmd.read_bits, 1'b0, 1'b1);
      end
    endcase
  endfunction

  function automatic i2cbpg_pkg::in_t make_cmd(input logic [1:0] func,
                                               input logic [7:0] tx,
                                               input logic mack, input logic [7:0] rd,
                                               input logic sack);
    i2cbpg_pkg::in_t cmd;
    cmd.func             = func;
    cmd.tx_byte          = tx;
    cmd.master_ack       = mack;
    cmd.read_bits        = rd;
    cmd.slave_ack_sample = sack;
    return cmd;
  endfunction

  function automatic i2cbpg_pkg::in_t random_cmd(input logic [1:0] func);
    return make_cmd(func, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
  endfunction

  function automatic string phase_str(input i2cbpg_pkg::out_t ph);
    return $sformatf("scl=%b en=%b sda=%b rx=%h ack=%b last=%b", ph.scl_level,
                     ph.sda_enable, ph.sda_level, ph.rx_byte, ph.ack_seen, ph.last);
  endfunction

  task automatic issue_command(input i2cbpg_pkg::in_t cmd);
    int gap;
    if (idle_en && $urandom_range(99) < 15) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!in_ready_o);
    predict_phases(cmd);
  endtask

  task automatic report_failure(input string what, input i2cbpg_pkg::out_t exp,
                                input i2cbpg_pkg::out_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: expected %s, got %s", $realtime, what, phase_str(exp),
               phase_str(got));
    end
  endtask

  task automatic check_phase(input i2cbpg_pkg::out_t got);
    i2cbpg_pkg::out_t exp;
    if (expected_phases.size() == 0) begin
      report_failure("unexpected transfer", '0, got);
    end else begin
      exp = expected_phases.pop_front();
      if (got.scl_level !== exp.scl_level || got.sda_enable !== exp.sda_enable ||
          got.sda_level !== exp.sda_level || got.rx_byte !== exp.rx_byte ||
          got.ack_seen !== exp.ack_seen || got.last !== exp.last) begin
        report_failure("phase mismatch", exp, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid_o && out_ready) begin
      check_phase(out_data_o);
    end
  end

  initial begin : phase_sink
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (idle_en) begin
        out_ready <= ($urandom_range(99) >= 15);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    issue_command(make_cmd(i2cbpg_pkg::FuncStart, 8'h00, 1'b0, 8'h00, 1'b0));
    issue_command(make_cmd(i2cbpg_pkg::FuncWrite, 8'h00, 1'b0, 8'h00, 1'b0));
    issue_command(make_cmd(i2cbpg_pkg::FuncWrite, 8'hFF, 1'b1, 8'hFF, 1'b1));
    issue_command(make_cmd(i2cbpg_pkg::FuncWrite, 8'hA5, 1'b0, 8'h00, 1'b1));
    issue_command(make_cmd(i2cbpg_pkg::FuncWrite, 8'h5A, 1'b1, 8'hFF, 1'b0));
    issue_command(make_cmd(i2cbpg_pkg::FuncRead, 8'hFF, 1'b0, 8'h00, 1'b1));
    issue_command(make_cmd(i2cbpg_pkg::FuncRead, 8'h00, 1'b1, 8'hFF, 1'b0));
    issue_command(make_cmd(i2cbpg_pkg::FuncRead, 8'h3C, 1'b0, 8'h5A, 1'b0));
    issue_command(make_cmd(i2cbpg_pkg::FuncRead, 8'hC3, 1'b1, 8'hA5, 1'b1));
    issue_command(make_cmd(i2cbpg_pkg::FuncStop, 8'hFF, 1'b1, 8'hFF, 1'b1));
    issue_command(make_cmd(i2cbpg_pkg::FuncStart, 8'hFF, 1'b1, 8'hFF, 1'b1));
    issue_command(make_cmd(i2cbpg_pkg::FuncStart, 8'h00, 1'b0, 8'h00, 1'b0));
    issue_command(make_cmd(i2cbpg_pkg::FuncStop, 8'h00, 1'b0, 8'h00, 1'b0));
    issue_command(make_cmd(i2cbpg_pkg::FuncStop, 8'h00, 1'b0, 8'h00, 1'b0));
  endtask

  task automatic random_transaction(output int sent);
    int n;
    logic is_read;
    n       = $urandom_range(1, 4);
    is_read = 1'($urandom);
    issue_command(random_cmd(i2cbpg_pkg::FuncStart));
    issue_command(random_cmd(i2cbpg_pkg::FuncWrite));
    for (int i = 0; i < n; i++) begin
      issue_command(random_cmd(is_read ? i2cbpg_pkg::FuncRead : i2cbpg_pkg::FuncWrite));
    end
    issue_command(random_cmd(i2cbpg_pkg::FuncStop));
    sent = n + 3;
  endtask

  task automatic test_random();
    int sent;
    int total;
    total = 0;
    while (total < 305) begin
      if (total >= 120 && total < 190) begin
        idle_en = 1'b0;
      end else begin
        idle_en = 1'b1;
      end
      if ($urandom_range(99) < 20) begin
        issue_command(random_cmd(2'($urandom)));
        total++;
      end else begin
        random_transaction(sent);
        total += sent;
      end
    end
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) begin
      issue_command(random_cmd(2'($urandom)));
    end
  endtask

  initial begin : main
    int guard;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random();

    in_valid <= 1'b0;
    guard = 0;
    while (expected_phases.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (expected_phases.size() != 0) begin
      fail_count++;
      $display("%0d phases never arrived", expected_phases.size());
    end

    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

// File: sim.f
src/i2cbpg_pkg.sv
src/i2cbpg_ctrl.sv
src/i2cbpg_dp.sv
src/i2c_master_byte_phase_generator.sv
dv/tb.sv
